[src/bpl_pkg.sv]
// Package for the bounded positional list unit.
// Holds the capacity, widths, operation and status codes and the result beat type.
// No dependencies.
`default_nettype none

package bpl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_REAR  = 3'd1,
        KIND_INS_AT    = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_REAR  = 3'd4,
        KIND_DEL_AT    = 3'd5,
        KIND_DUMP      = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   element;
        logic                element_valid;
        logic [LEN_W-1:0]    length;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

[src/bpl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module bpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/bpl_seq.sv]
// Operation sequencer for the bounded positional list: decodes each item,
// shifts entries through the RAM read/write ports and walks the list on a dump.
// Depends on bpl_pkg.
`default_nettype none

module bpl_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bpl_pkg::KIND_W-1:0]     in_kind,
    input  wire logic [bpl_pkg::DATA_W-1:0]     in_value,
    input  wire logic [bpl_pkg::POS_W-1:0]      in_position,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output bpl_pkg::res_t                       res,
    output logic                                ram_we,
    output logic [bpl_pkg::IDX_W-1:0]           ram_waddr,
    output logic [bpl_pkg::DATA_W-1:0]          ram_wdata,
    output logic                                ram_re,
    output logic [bpl_pkg::IDX_W-1:0]           ram_raddr,
    input  wire logic [bpl_pkg::DATA_W-1:0]     ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_DRD,
        S_DOUT,
        S_RESP
    } state_t;

    state_t                        state_reg, state_next;
    logic [bpl_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [bpl_pkg::CNT_W-1:0]     ptr_reg, ptr_next;
    logic [bpl_pkg::CNT_W-1:0]     pos_reg, pos_next;
    logic [bpl_pkg::DATA_W-1:0]    value_reg, value_next;
    bpl_pkg::status_t              status_reg, status_next;
    logic                          pend_reg, pend_next;
    logic [bpl_pkg::IDX_W-1:0]     pend_addr_reg, pend_addr_next;

    logic [bpl_pkg::CNT_W-1:0]     ptr_dec, ptr_inc, count_dec, pos_in, pos_inc;
    logic                          empty, full, dump_last;

    assign ptr_dec   = ptr_reg - 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign pos_in    = bpl_pkg::CNT_W'(in_position);
    assign pos_inc   = pos_in + 1'b1;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == bpl_pkg::CNT_W'(bpl_pkg::CAPACITY));
    assign dump_last = (ptr_reg == count_dec);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = '{status: status_reg, element: '0, element_valid: 1'b0,
                      length: bpl_pkg::LEN_W'(count_reg), last: 1'b1};

        // a pending read from the previous cycle lands one place over
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[bpl_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    value_next  = in_value;
                    status_next = bpl_pkg::ST_OK;
                    state_next  = S_RESP;
                    case (bpl_pkg::kind_t'(in_kind))
                        bpl_pkg::KIND_INS_FRONT,
                        bpl_pkg::KIND_INS_REAR,
                        bpl_pkg::KIND_INS_AT: begin
                            if (bpl_pkg::kind_t'(in_kind) == bpl_pkg::KIND_INS_FRONT) begin
                                pos_next = '0;
                            end else if (bpl_pkg::kind_t'(in_kind) == bpl_pkg::KIND_INS_REAR) begin
                                pos_next = count_reg;
                            end else begin
                                pos_next = pos_in;
                            end
                            ptr_next = count_reg;
                            if (bpl_pkg::kind_t'(in_kind) == bpl_pkg::KIND_INS_AT &&
                                pos_in > count_reg) begin
                                status_next = bpl_pkg::ST_INVALID;
                            end else if (full) begin
                                status_next = bpl_pkg::ST_FULL;
                            end else begin
                                state_next = S_INS;
                            end
                        end
                        bpl_pkg::KIND_DEL_FRONT: begin
                            if (empty) begin
                                status_next = bpl_pkg::ST_EMPTY;
                            end else begin
                                ptr_next   = bpl_pkg::CNT_W'(1);
                                state_next = S_DEL;
                            end
                        end
                        bpl_pkg::KIND_DEL_REAR: begin
                            if (empty) begin
                                status_next = bpl_pkg::ST_EMPTY;
                            end else begin
                                // nothing behind the rear entry to move
                                ptr_next   = count_reg;
                                state_next = S_DEL;
                            end
                        end
                        bpl_pkg::KIND_DEL_AT: begin
                            if (pos_in >= count_reg) begin
                                status_next = bpl_pkg::ST_INVALID;
                            end else begin
                                ptr_next   = pos_inc;
                                state_next = S_DEL;
                            end
                        end
                        bpl_pkg::KIND_DUMP: begin
                            if (empty) begin
                                status_next = bpl_pkg::ST_EMPTY;
                            end else begin
                                ptr_next   = '0;
                                state_next = S_DRD;
                            end
                        end
                        default: begin
                            status_next = bpl_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_INS: begin
                // walk from the tail down to pos: read i-1, write i next cycle
                ram_we = pend_reg;
                if (ptr_reg != pos_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = ptr_dec[bpl_pkg::IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[bpl_pkg::IDX_W-1:0];
                    ptr_next       = ptr_dec;
                end else if (!pend_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[bpl_pkg::IDX_W-1:0];
                    ram_wdata  = value_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
            end
            S_DEL: begin
                // walk upward: read i+1, write i next cycle
                ram_we = pend_reg;
                if (ptr_reg != count_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = ptr_reg[bpl_pkg::IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_dec[bpl_pkg::IDX_W-1:0];
                    ptr_next       = ptr_inc;
                end else if (!pend_reg) begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end
            end
            S_DRD: begin
                ram_re     = 1'b1;
                state_next = S_DOUT;
            end
            S_DOUT: begin
                res_valid = 1'b1;
                res       = '{status: bpl_pkg::ST_OK, element: ram_rdata,
                              element_valid: 1'b1,
                              length: bpl_pkg::LEN_W'(count_reg), last: dump_last};
                if (res_ready) begin
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_inc;
                        state_next = S_DRD;
                    end
                end
            end
            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
        ptr_reg       <= ptr_next;
        pos_reg       <= pos_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        pend_addr_reg <= pend_addr_next;
    end

endmodule

`default_nettype wire

[src/bounded_positional_list_unit.sv]
// Flow, acceptance to last beat taken: a refused item goes straight to its status result; an
// insert or delete moves one RAM entry per cycle, then drains the pending write and either
// writes the new value or lowers the count; a dump reads out and presents each entry in turn.
// Throughput: one item at a time; the next item is taken once the last beat has left the
// sequencer, while that beat may still wait in the output register.
// Reset: synchronous, active low; clears the element count and handshakes. RAM contents are kept.
`default_nettype none

module bounded_positional_list_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bpl_pkg::KIND_W-1:0]   s_kind,
    input  wire logic signed [bpl_pkg::DATA_W-1:0] s_value,
    input  wire logic [bpl_pkg::POS_W-1:0]    s_position,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [bpl_pkg::STAT_W-1:0]        m_status,
    output logic signed [bpl_pkg::DATA_W-1:0] m_element,
    output logic                              m_element_valid,
    output logic [bpl_pkg::LEN_W-1:0]         m_length,
    output logic                              m_last
);

    logic                          res_valid, res_ready;
    bpl_pkg::res_t                 res;
    logic                          ram_we, ram_re;
    logic [bpl_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [bpl_pkg::DATA_W-1:0]    ram_wdata, ram_rdata;

    logic                          m_valid_reg;
    bpl_pkg::res_t                 out_reg;

    bpl_ram #(
        .WIDTH(bpl_pkg::DATA_W),
        .DEPTH(bpl_pkg::CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpl_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_kind     (s_kind),
        .in_value    (s_value),
        .in_position (s_position),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // output register: the sequencer moves on while a beat waits here
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_element       = out_reg.element;
    assign m_element_valid = out_reg.element_valid;
    assign m_length        = out_reg.length;
    assign m_last          = out_reg.last;

endmodule

`default_nettype wire

[src/bpl_checker.sv]
// Port-level checks for bounded_positional_list_unit, bound to the top level.
// Depends on bpl_pkg.
`default_nettype none

module bpl_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [bpl_pkg::STAT_W-1:0]   m_status,
    input wire logic [bpl_pkg::DATA_W-1:0]   m_element,
    input wire logic                         m_element_valid,
    input wire logic [bpl_pkg::LEN_W-1:0]    m_length,
    input wire logic                         m_last
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_last)
                                && $stable(m_status))
        else $error("result beat changed while stalled");

    // status-only results are single beats
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_element_valid |-> m_last && m_element == '0)
        else $error("status result not marked last or carries data");

    a_dump_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_element_valid |-> m_status == bpl_pkg::ST_OK && m_length != '0)
        else $error("dump beat with bad status or empty length");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length <= bpl_pkg::LEN_W'(bpl_pkg::CAPACITY))
        else $error("length above capacity");

    // within one dump the length does not move between beats
    a_dump_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_element_valid && !m_last ##1 m_valid
        |-> m_element_valid && m_length == $past(m_length))
        else $error("dump interrupted or length changed");

endmodule

bind bounded_positional_list_unit bpl_checker u_bpl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_element       (m_element),
    .m_element_valid (m_element_valid),
    .m_length        (m_length),
    .m_last          (m_last)
);

`default_nettype wire
